[src/bqc_pkg.sv]
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared widths, constants and types for the billboard quad corner pipeline.
// ----------------------------------------------------------------------------
package bqc_pkg;

  // Field widths
  localparam int DIR_W  = 16;   // direction component, Q1.14
  localparam int HS_W   = 16;   // half size, 1/256 units
  localparam int POS_W  = 19;   // corner position, 1/256 units
  localparam int V_W    = 17;   // negated direction, one extra bit for -(-32768)
  localparam int C_W    = 17;   // centre component
  localparam int RT_W   = 17;   // signed right component
  localparam int UP_W   = 22;   // signed up component
  localparam int SUM_W  = 24;   // unsaturated corner sum
  localparam int MAG_W  = 16;   // magnitude of a raw right component
  localparam int SQ_W   = 32;   // squared length of raw right
  localparam int NUM_W  = 32;   // magnitude times half size
  localparam int N2_W   = 64;   // square of the above
  localparam int SRCH_N = 16;   // result bits of the scale search, one per stage

  // Corner positions saturate to this range
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(262143);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(262144);

  // World z is the reference axis when 100 * |view y| >= 99 * 16384
  localparam logic [23:0] REF_LIMIT = 24'(99 * 16384);
  localparam logic [6:0]  REF_SCALE = 7'd100;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  // Item fields that ride alongside the arithmetic
  typedef struct packed {
    logic signed [C_W-1:0] c0;
    logic signed [C_W-1:0] c1;
    logic signed [C_W-1:0] c2;
    logic signed [V_W-1:0] v0;
    logic signed [V_W-1:0] v1;
    logic signed [V_W-1:0] v2;
    logic                  zsel;    // world z chosen as reference
    logic                  neg_a;   // sign of first raw right component
    logic                  neg_b;   // sign of second raw right component
    logic                  s_zero;  // raw right has zero length
    logic                  mir;
  } meta_t;

endpackage

[src/billboard_quad_corners.sv]
// ----------------------------------------------------------------------------
// billboard_quad_corners
// Four corners of a camera-facing square from a direction, half size and
// mirror flag. Positions in 1/256 units, saturated.
// ----------------------------------------------------------------------------
// Path: a request passes slots 1 to 3, the search stages, slots 20 and 21 and
//   the hold stage, which then gives one corner per cycle while out_ready is high.
// Output: the four corners of a request share the single output channel. New
//   requests enter only as the hold stage frees; the 21-stage pipeline holds many requests.
// Reset: rst clears all valid bits and the corner counter; payload is not reset.
module billboard_quad_corners (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [bqc_pkg::DIR_W-1:0] dir_x,
  input  logic signed [bqc_pkg::DIR_W-1:0] dir_y,
  input  logic signed [bqc_pkg::DIR_W-1:0] dir_z,
  input  logic        [bqc_pkg::HS_W-1:0]  half_size,
  input  logic                             mirror_u,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic        [1:0]                corner_index,
  output logic signed [bqc_pkg::POS_W-1:0] pos_x,
  output logic signed [bqc_pkg::POS_W-1:0] pos_y,
  output logic signed [bqc_pkg::POS_W-1:0] pos_z,
  output logic                             tex_u,
  output logic                             tex_v,
  output logic                             last_corner
);

  localparam int NS  = 3 + bqc_pkg::SRCH_N + 2;  // pipeline slots before hold
  localparam int SL3 = 3;
  localparam int SLS = SL3 + bqc_pkg::SRCH_N;     // slot that holds the search result
  localparam int PW  = 2 * bqc_pkg::V_W;          // product width
  localparam int DW  = PW + 1;                    // difference width

  logic             en;
  logic [NS:1]      vld;
  bqc_pkg::meta_t   meta_q [1:NS];

  // Advance everything when the hold stage is free or is giving its last corner
  logic             hold_valid;
  logic [1:0]       k;
  assign en       = !hold_valid || (out_ready && (k == bqc_pkg::CORNER_LAST));
  assign in_ready = en;

  // ---------------------------------------------------------------- slot 1
  logic signed [bqc_pkg::V_W-1:0] d0, d1, d2;
  logic signed [21:0]             cn0, cn1, cn2;
  logic [16:0]                    ay;
  logic                           zsel;
  logic signed [bqc_pkg::V_W-1:0] rr_a, rr_b;
  bqc_pkg::meta_t                 meta_in;

  function automatic logic signed [bqc_pkg::C_W-1:0] centre(input logic signed [21:0] n);
    logic [20:0] mag;
    logic [16:0] r;
    mag = n[21] ? 21'(-n) : n[20:0];
    r   = 17'((mag + 21'd8) >> 4);
    return n[21] ? -$signed(r) : $signed(r);
  endfunction

  assign d0  = bqc_pkg::V_W'(dir_x);
  assign d1  = bqc_pkg::V_W'(dir_y);
  assign d2  = bqc_pkg::V_W'(dir_z);
  assign cn0 = 22'(d0) * 22'sd25;
  assign cn1 = 22'(d1) * 22'sd25;
  assign cn2 = 22'(d2) * 22'sd25;
  assign ay  = d1[16] ? 17'(-d1) : d1;
  assign zsel = (24'(ay) * 24'(bqc_pkg::REF_SCALE)) >= bqc_pkg::REF_LIMIT;
  // Raw right: view x up = (d2, 0, -d0); view x z = (-d1, d0, 0)
  assign rr_a = zsel ? -d1 : d2;
  assign rr_b = zsel ? d0 : -d0;

  always_comb begin
    meta_in.c0     = centre(cn0);
    meta_in.c1     = centre(cn1);
    meta_in.c2     = centre(cn2);
    meta_in.v0     = -d0;
    meta_in.v1     = -d1;
    meta_in.v2     = -d2;
    meta_in.zsel   = zsel;
    meta_in.neg_a  = rr_a[16];
    meta_in.neg_b  = rr_b[16];
    meta_in.s_zero = 1'b0;
    meta_in.mir    = mirror_u;
  end

  logic [bqc_pkg::MAG_W-1:0] mag_a1, mag_b1;
  logic [bqc_pkg::HS_W-1:0]  h1;
  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[1] <= meta_in;
      mag_a1    <= bqc_pkg::MAG_W'(rr_a[16] ? -rr_a : rr_a);
      mag_b1    <= bqc_pkg::MAG_W'(rr_b[16] ? -rr_b : rr_b);
      h1        <= half_size;
    end
  end

  // ---------------------------------------------------------------- slot 2
  logic [bqc_pkg::SQ_W-1:0]  sq_a2, sq_b2;
  logic [bqc_pkg::NUM_W-1:0] num_a2, num_b2;
  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[2] <= meta_q[1];
      sq_a2     <= bqc_pkg::SQ_W'(mag_a1) * bqc_pkg::SQ_W'(mag_a1);
      sq_b2     <= bqc_pkg::SQ_W'(mag_b1) * bqc_pkg::SQ_W'(mag_b1);
      num_a2    <= bqc_pkg::NUM_W'(mag_a1) * bqc_pkg::NUM_W'(h1);
      num_b2    <= bqc_pkg::NUM_W'(mag_b1) * bqc_pkg::NUM_W'(h1);
    end
  end

  // ---------------------------------------------------------------- slot 3
  logic [bqc_pkg::SQ_W-1:0] s3, s_sum;
  logic [bqc_pkg::N2_W-1:0] n2_a3, n2_b3;
  bqc_pkg::meta_t           meta3_next;
  assign s_sum = sq_a2 + sq_b2;

  // Mark a zero-length right before the search
  always_comb begin
    meta3_next        = meta_q[2];
    meta3_next.s_zero = (s_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[3] <= meta3_next;
      s3        <= s_sum;
      n2_a3     <= bqc_pkg::N2_W'(num_a2) * bqc_pkg::N2_W'(num_a2);
      n2_b3     <= bqc_pkg::N2_W'(num_b2) * bqc_pkg::N2_W'(num_b2);
    end
  end

  // ------------------------------------------------------- scale search
  logic [bqc_pkg::SRCH_N-1:0] m_a, m_b;

  bqc_scale u_scale_a (.clk(clk), .en(en), .s(s3), .n2(n2_a3), .m(m_a));
  bqc_scale u_scale_b (.clk(clk), .en(en), .s(s3), .n2(n2_b3), .m(m_b));

  // Carry item fields alongside the search
  genvar g;
  generate
    for (g = SL3 + 1; g <= SLS; g++) begin : g_meta
      always_ff @(posedge clk) begin
        if (en) begin
          meta_q[g] <= meta_q[g-1];
        end
      end
    end
  endgenerate

  // ------------------------------------------------- slot 20: right, products
  logic signed [bqc_pkg::RT_W-1:0] rta, rtb, rt0c, rt1c, rt2c;
  assign rta  = meta_q[SLS].s_zero ? '0 :
                (meta_q[SLS].neg_a ? -$signed(bqc_pkg::RT_W'(m_a)) : $signed(bqc_pkg::RT_W'(m_a)));
  assign rtb  = meta_q[SLS].s_zero ? '0 :
                (meta_q[SLS].neg_b ? -$signed(bqc_pkg::RT_W'(m_b)) : $signed(bqc_pkg::RT_W'(m_b)));
  assign rt0c = rta;
  assign rt1c = meta_q[SLS].zsel ? rtb : '0;
  assign rt2c = meta_q[SLS].zsel ? '0 : rtb;

  logic signed [bqc_pkg::RT_W-1:0] rt0_4, rt1_4, rt2_4;
  logic signed [PW-1:0]            pa0, pb0, pa1, pb1, pa2, pb2;
  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[SLS+1] <= meta_q[SLS];
      rt0_4 <= rt0c;
      rt1_4 <= rt1c;
      rt2_4 <= rt2c;
      pa0   <= PW'(rt1c) * PW'(meta_q[SLS].v2);
      pb0   <= PW'(rt2c) * PW'(meta_q[SLS].v1);
      pa1   <= PW'(rt2c) * PW'(meta_q[SLS].v0);
      pb1   <= PW'(rt0c) * PW'(meta_q[SLS].v2);
      pa2   <= PW'(rt0c) * PW'(meta_q[SLS].v1);
      pb2   <= PW'(rt1c) * PW'(meta_q[SLS].v0);
    end
  end

  // ------------------------------------------------------ slot 21: up
  function automatic logic signed [bqc_pkg::UP_W-1:0] up_round(
    input logic signed [PW-1:0] a,
    input logic signed [PW-1:0] b
  );
    logic signed [DW-1:0] dif;
    logic [DW-1:0]        mag;
    logic [bqc_pkg::UP_W-1:0] r;
    dif = DW'(a) - DW'(b);
    mag = dif[DW-1] ? DW'(-dif) : DW'(dif);
    r   = bqc_pkg::UP_W'((mag + DW'(8192)) >> 14);
    return dif[DW-1] ? -$signed(r) : $signed(r);
  endfunction

  logic signed [bqc_pkg::RT_W-1:0] rt0_5, rt1_5, rt2_5;
  logic signed [bqc_pkg::UP_W-1:0] up0_5, up1_5, up2_5;
  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[NS] <= meta_q[SLS+1];
      rt0_5 <= rt0_4;
      rt1_5 <= rt1_4;
      rt2_5 <= rt2_4;
      up0_5 <= up_round(pa0, pb0);
      up1_5 <= up_round(pa1, pb1);
      up2_5 <= up_round(pa2, pb2);
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:1], in_valid};
    end
  end

  // ---------------------------------------------------- hold and emit
  bqc_pkg::meta_t                  hold;
  logic signed [bqc_pkg::RT_W-1:0] h_rt0, h_rt1, h_rt2;
  logic signed [bqc_pkg::UP_W-1:0] h_up0, h_up1, h_up2;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      k          <= '0;
    end else if (en) begin
      hold_valid <= vld[NS];
      k          <= '0;
    end else if (out_ready) begin
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold  <= meta_q[NS];
      h_rt0 <= rt0_5;
      h_rt1 <= rt1_5;
      h_rt2 <= rt2_5;
      h_up0 <= up0_5;
      h_up1 <= up1_5;
      h_up2 <= up2_5;
    end
  end

  function automatic logic signed [bqc_pkg::POS_W-1:0] corner(
    input logic signed [bqc_pkg::C_W-1:0]  c,
    input logic signed [bqc_pkg::RT_W-1:0] r,
    input logic signed [bqc_pkg::UP_W-1:0] u,
    input logic                            pr,
    input logic                            pu
  );
    logic signed [bqc_pkg::SUM_W-1:0] sum;
    sum = bqc_pkg::SUM_W'(c)
        + (pr ? bqc_pkg::SUM_W'(r) : -bqc_pkg::SUM_W'(r))
        + (pu ? bqc_pkg::SUM_W'(u) : -bqc_pkg::SUM_W'(u));
    if (sum > bqc_pkg::POS_MAX) begin
      sum = bqc_pkg::POS_MAX;
    end else if (sum < bqc_pkg::POS_MIN) begin
      sum = bqc_pkg::POS_MIN;
    end
    return sum[bqc_pkg::POS_W-1:0];
  endfunction

  // Right is added on corners one and two, up on corners zero and one
  logic pos_r, pos_u;
  assign pos_r = k[0] ^ k[1];
  assign pos_u = ~k[1];

  assign out_valid    = hold_valid;
  assign corner_index = k;
  assign pos_x        = corner(hold.c0, h_rt0, h_up0, pos_r, pos_u);
  assign pos_y        = corner(hold.c1, h_rt1, h_up1, pos_r, pos_u);
  assign pos_z        = corner(hold.c2, h_rt2, h_up2, pos_r, pos_u);
  assign tex_u        = pos_r ^ hold.mir;
  assign tex_v        = k[1];
  assign last_corner  = (k == bqc_pkg::CORNER_LAST);

  // ------------------------------------------------------- assertions
  a_corner_wrap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_corner) |=> (corner_index == 2'd0))
    else $error("corner counter did not restart after the last corner");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_zero_right: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold.s_zero) |->
      (h_rt0 == '0 && h_rt1 == '0 && h_rt2 == '0 && h_up0 == '0 && h_up1 == '0 &&
       h_up2 == '0))
    else $error("zero-length right gave non-zero right or up");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (!hold_valid && vld == '0))
    else $error("valid state not cleared by reset");

endmodule

[src/bqc_scale.sv]
// ----------------------------------------------------------------------------
// bqc_scale
// Pipelined bit search: m is the largest value with m*m*s <= n2, one result
// bit per stage, most significant first. m*m*s and m*s are kept updated with
// shifts and adds only.
// ----------------------------------------------------------------------------
module bqc_scale (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bqc_pkg::SQ_W-1:0]   s,
  input  logic [bqc_pkg::N2_W-1:0]   n2,
  output logic [bqc_pkg::SRCH_N-1:0] m
);

  localparam int N   = bqc_pkg::SRCH_N;
  localparam int QW  = bqc_pkg::SQ_W + N;      // m * s
  localparam int CW  = bqc_pkg::N2_W + 2;      // candidate compare width

  logic [bqc_pkg::N2_W-1:0]   p_q [0:N];       // m*m*s
  logic [QW-1:0]              q_q [0:N];       // m*s
  logic [bqc_pkg::SQ_W-1:0]   s_q [0:N];
  logic [bqc_pkg::N2_W-1:0]   n_q [0:N];
  logic [N-1:0]               m_q [0:N];

  // Stage 0 is the unregistered input
  assign p_q[0] = '0;
  assign q_q[0] = '0;
  assign s_q[0] = s;
  assign n_q[0] = n2;
  assign m_q[0] = '0;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_step
      localparam int K = N - 1 - g;
      logic [CW-1:0] cand;
      logic          take;

      // Try setting bit K: (m + 2^K)^2 s = m^2 s + 2^(K+1) m s + 2^(2K) s
      assign cand = CW'(p_q[g]) + (CW'(q_q[g]) << (K + 1)) + (CW'(s_q[g]) << (2 * K));
      assign take = (cand <= CW'(n_q[g]));

      // Advance one bit
      always_ff @(posedge clk) begin
        if (en) begin
          s_q[g+1] <= s_q[g];
          n_q[g+1] <= n_q[g];
          if (take) begin
            p_q[g+1] <= cand[bqc_pkg::N2_W-1:0];
            q_q[g+1] <= q_q[g] + (QW'(s_q[g]) << K);
            m_q[g+1] <= m_q[g] | (N'(1) << K);
          end else begin
            p_q[g+1] <= p_q[g];
            q_q[g+1] <= q_q[g];
            m_q[g+1] <= m_q[g];
          end
        end
      end
    end
  endgenerate

  assign m = m_q[N];

endmodule
